/* src/cwbc_pkg.sv */
// ============================================================================
// Clock write-back block cache: shared package
// Widths, request and result codes, and the types that pass between the
// slot cells and the controller.
// ============================================================================
package cwbc_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int CFG_W    = 5;
    localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int KIND_W   = 2;
    localparam int FILE_W   = 10;
    localparam int BLOCK_W  = 32;
    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 4;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_BITS    = FILE_W + BLOCK_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = SLOT_W + 1 + FILE_W + BLOCK_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_READ_HIT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_HIT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FILL      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_EVICT     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FLUSH_WB  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FLUSH_END = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WHIT,
        OP_FILL,
        OP_EVICT,
        OP_FLUSH
    } cell_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                 capture;
        cell_op_t             op;
        logic [FILE_W-1:0]    file;
        logic [BLOCK_W-1:0]   block;
        logic                 dirty;
    } cell_cmd_t;

    // Priority chain passed from each cell to the next one up.
    typedef struct packed {
        logic hit;
        logic unref;
        logic fl;
    } chain_t;

    // What each cell reports back to the controller.
    typedef struct packed {
        logic                 sel_hit;
        logic                 sel_vic;
        logic                 sel_fl;
        logic                 dirty;
        logic [FILE_W-1:0]    file;
        logic [BLOCK_W-1:0]   block;
    } cell_stat_t;

    // Low bits of a slot index as carried in the result.
    function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

/* src/cwbc_cell.sv */
// ============================================================================
// Clock write-back block cache: slot cell
// Holds one slot's tag, reference and dirty bits, registers its compare
// results and takes part in the hit, victim and flush priority chains.
// ============================================================================
module cwbc_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cwbc_pkg::cell_cmd_t   cmd,
    input  logic                  filled,
    input  logic                  target,
    input  cwbc_pkg::chain_t      chain_in,
    output cwbc_pkg::chain_t      chain_out,
    output cwbc_pkg::cell_stat_t  stat
);

    logic [cwbc_pkg::FILE_W-1:0]  file_reg;
    logic [cwbc_pkg::BLOCK_W-1:0] block_reg;
    logic                         ref_reg;
    logic                         dirty_reg;
    logic                         match_reg;
    logic                         fmatch_reg;
    logic                         unref;

    assign unref = filled && !ref_reg;

    assign chain_out.hit   = chain_in.hit   || match_reg;
    assign chain_out.unref = chain_in.unref || unref;
    assign chain_out.fl    = chain_in.fl    || fmatch_reg;

    assign stat.sel_hit = match_reg  && !chain_in.hit;
    assign stat.sel_vic = unref      && !chain_in.unref;
    assign stat.sel_fl  = fmatch_reg && !chain_in.fl;
    assign stat.dirty   = dirty_reg;
    assign stat.file    = file_reg;
    assign stat.block   = block_reg;

    // Tag storage has no reset; a slot is only looked at once it is filled.
    always_ff @(posedge aclk) begin
        if ((cmd.op == cwbc_pkg::OP_FILL || cmd.op == cwbc_pkg::OP_EVICT) && target) begin
            file_reg  <= cmd.file;
            block_reg <= cmd.block;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg    <= 1'b0;
            dirty_reg  <= 1'b0;
            match_reg  <= 1'b0;
            fmatch_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                match_reg  <= filled && file_reg == cmd.file && block_reg == cmd.block;
                fmatch_reg <= filled && file_reg == cmd.file && dirty_reg;
            end
            unique case (cmd.op)
                cwbc_pkg::OP_WHIT: begin
                    if (target) begin
                        ref_reg   <= 1'b1;
                        dirty_reg <= 1'b1;
                    end
                end
                cwbc_pkg::OP_FILL: begin
                    if (target) begin
                        ref_reg   <= 1'b1;
                        dirty_reg <= cmd.dirty;
                    end
                end
                cwbc_pkg::OP_EVICT: begin
                    // Every slot the clock hand passes loses its reference bit.
                    if (target) begin
                        ref_reg   <= 1'b1;
                        dirty_reg <= cmd.dirty;
                    end else if (!chain_in.unref) begin
                        ref_reg <= 1'b0;
                    end
                end
                cwbc_pkg::OP_FLUSH: begin
                    if (target) begin
                        dirty_reg  <= 1'b0;
                        fmatch_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* src/cwbc_ctrl.sv */
// ============================================================================
// Clock write-back block cache: controller
// Takes requests, decides hit, fill, eviction or flush step from the cell
// chain, drives the cell commands and holds the result register.
// ============================================================================
module cwbc_ctrl (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [cwbc_pkg::KIND_W-1:0]                s_kind,
    input  logic [cwbc_pkg::FILE_W-1:0]                s_file,
    input  logic [cwbc_pkg::BLOCK_W-1:0]               s_block,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [cwbc_pkg::ACTION_W-1:0]              m_action,
    output logic [cwbc_pkg::SLOT_W-1:0]                m_slot,
    output logic                                       m_wb,
    output logic [cwbc_pkg::FILE_W-1:0]                m_old_file,
    output logic [cwbc_pkg::BLOCK_W-1:0]               m_old_block,
    output logic                                       m_last,
    input  logic                                       cfg_wr_en,
    input  logic [cwbc_pkg::CFG_W-1:0]                 cfg_wr_data,
    input  cwbc_pkg::cell_stat_t [cwbc_pkg::SLOTS-1:0] stat,
    input  cwbc_pkg::chain_t                           chain_end,
    output cwbc_pkg::cell_cmd_t                        cmd,
    output logic [cwbc_pkg::SLOTS-1:0]                 filled,
    output logic [cwbc_pkg::SLOTS-1:0]                 target
);

    typedef enum logic {
        ST_IDLE,
        ST_DECIDE
    } state_t;

    state_t                          state_reg;
    logic [cwbc_pkg::CFG_W-1:0]      max_reg;
    logic [cwbc_pkg::CNT_W-1:0]      count_reg;
    logic [cwbc_pkg::KIND_W-1:0]     kind_reg;
    logic [cwbc_pkg::FILE_W-1:0]     file_reg;
    logic [cwbc_pkg::BLOCK_W-1:0]    block_reg;
    logic                            m_tvalid_reg;
    logic [cwbc_pkg::ACTION_W-1:0]   action_reg;
    logic [cwbc_pkg::SLOT_W-1:0]     slot_reg;
    logic                            wb_reg;
    logic [cwbc_pkg::FILE_W-1:0]     old_file_reg;
    logic [cwbc_pkg::BLOCK_W-1:0]    old_block_reg;
    logic                            last_reg;

    logic                            accept;
    logic                            out_free;
    logic                            emit;
    logic [cwbc_pkg::LIM_W-1:0]      cfg_ext;
    logic [cwbc_pkg::LIM_W-1:0]      limit;
    logic                            room;
    logic [cwbc_pkg::IDX_W-1:0]      hit_idx;
    logic [cwbc_pkg::IDX_W-1:0]      vic_idx;
    logic [cwbc_pkg::IDX_W-1:0]      fl_idx;
    logic [cwbc_pkg::IDX_W-1:0]      tgt_idx;
    cwbc_pkg::cell_op_t              op;
    logic [cwbc_pkg::FILE_W-1:0]     pick_file;
    logic [cwbc_pkg::BLOCK_W-1:0]    pick_block;
    logic                            pick_dirty;
    logic [cwbc_pkg::ACTION_W-1:0]   action_next;
    logic                            tag_next;
    logic                            last_next;

    assign accept   = s_tvalid && state_reg == ST_IDLE;
    assign s_tready = state_reg == ST_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;

    // Register value 0 acts as one slot, anything above the slot count as all.
    assign cfg_ext = cwbc_pkg::LIM_W'(max_reg);
    always_comb begin
        if (cfg_ext == '0) begin
            limit = cwbc_pkg::LIM_W'(1);
        end else if (cfg_ext > cwbc_pkg::LIM_W'(cwbc_pkg::SLOTS)) begin
            limit = cwbc_pkg::LIM_W'(cwbc_pkg::SLOTS);
        end else begin
            limit = cfg_ext;
        end
    end
    assign room = cwbc_pkg::LIM_W'(count_reg) < limit;

    always_comb begin
        hit_idx = '0;
        vic_idx = '0;
        fl_idx  = '0;
        for (int i = 0; i < cwbc_pkg::SLOTS; i++) begin
            filled[i] = cwbc_pkg::CNT_W'(i) < count_reg;
            if (stat[i].sel_hit) hit_idx = hit_idx | cwbc_pkg::IDX_W'(i);
            if (stat[i].sel_vic) vic_idx = vic_idx | cwbc_pkg::IDX_W'(i);
            if (stat[i].sel_fl)  fl_idx  = fl_idx  | cwbc_pkg::IDX_W'(i);
        end
    end

    always_comb begin
        op          = cwbc_pkg::OP_NONE;
        tgt_idx     = '0;
        emit        = 1'b0;
        action_next = cwbc_pkg::ACT_FLUSH_END;
        tag_next    = 1'b0;
        last_next   = 1'b1;
        if (state_reg == ST_DECIDE && out_free) begin
            emit = 1'b1;
            if (kind_reg == cwbc_pkg::KIND_FLUSH) begin
                if (chain_end.fl) begin
                    op          = cwbc_pkg::OP_FLUSH;
                    tgt_idx     = fl_idx;
                    action_next = cwbc_pkg::ACT_FLUSH_WB;
                    tag_next    = 1'b1;
                    last_next   = 1'b0;
                end
            end else if (chain_end.hit) begin
                tgt_idx = hit_idx;
                if (kind_reg == cwbc_pkg::KIND_WRITE) begin
                    op          = cwbc_pkg::OP_WHIT;
                    action_next = cwbc_pkg::ACT_WRITE_HIT;
                end else begin
                    action_next = cwbc_pkg::ACT_READ_HIT;
                end
            end else if (room) begin
                op          = cwbc_pkg::OP_FILL;
                tgt_idx     = count_reg[cwbc_pkg::IDX_W-1:0];
                action_next = cwbc_pkg::ACT_FILL;
            end else begin
                // With every slot referenced the hand wraps to slot 0.
                op          = cwbc_pkg::OP_EVICT;
                tgt_idx     = chain_end.unref ? vic_idx : '0;
                action_next = cwbc_pkg::ACT_EVICT;
                tag_next    = 1'b1;
            end
        end
    end

    always_comb begin
        pick_file  = '0;
        pick_block = '0;
        pick_dirty = 1'b0;
        for (int i = 0; i < cwbc_pkg::SLOTS; i++) begin
            target[i]  = op != cwbc_pkg::OP_NONE && tgt_idx == cwbc_pkg::IDX_W'(i);
            pick_file  = pick_file  | (stat[i].file  & {cwbc_pkg::FILE_W{target[i]}});
            pick_block = pick_block | (stat[i].block & {cwbc_pkg::BLOCK_W{target[i]}});
            pick_dirty = pick_dirty | (stat[i].dirty & target[i]);
        end
    end

    assign cmd.capture = accept;
    assign cmd.op      = op;
    assign cmd.file    = (state_reg == ST_IDLE) ? s_file  : file_reg;
    assign cmd.block   = (state_reg == ST_IDLE) ? s_block : block_reg;
    assign cmd.dirty   = kind_reg == cwbc_pkg::KIND_WRITE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_reg      <= cwbc_pkg::CFG_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) max_reg <= cfg_wr_data;
            // A new result may load in the same cycle that the old one leaves.
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg  <= s_kind;
                        file_reg  <= s_file;
                        block_reg <= s_block;
                        unique case (s_kind)
                            cwbc_pkg::KIND_READ,
                            cwbc_pkg::KIND_WRITE,
                            cwbc_pkg::KIND_FLUSH: state_reg <= ST_DECIDE;
                            default:              state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_DECIDE: begin
                    if (emit) begin
                        action_reg    <= action_next;
                        slot_reg      <= (action_next == cwbc_pkg::ACT_FLUSH_END) ?
                                         '0 : cwbc_pkg::slot_field(tgt_idx);
                        wb_reg        <= tag_next && pick_dirty;
                        old_file_reg  <= tag_next ? pick_file  : '0;
                        old_block_reg <= tag_next ? pick_block : '0;
                        last_reg      <= last_next;
                        if (op == cwbc_pkg::OP_FILL) count_reg <= count_reg + 1'b1;
                        if (last_next) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_action    = action_reg;
    assign m_slot      = slot_reg;
    assign m_wb        = wb_reg;
    assign m_old_file  = old_file_reg;
    assign m_old_block = old_block_reg;
    assign m_last      = last_reg;

endmodule

/* src/clock_writeback_block_cache.sv */
// ============================================================================
// Clock write-back block cache directory
// Fully associative directory with clock (second chance) replacement, built
// as a row of slot cells linked by priority chains, under one controller.
// ============================================================================
//
//  Channel  Direction  Contents
//  s_       in         request: tuser = kind, tdata = file id, block number
//  m_       out        result: tuser = action, tdata = slot, writeback flag,
//                      old file id, old block number; tlast = final result
//  cfg_     in         max_pages_in_use, written whenever cfg_wr_en is high
//
// For a read or write the cells register their tag compares at the accepting
// edge, and in the decision state the chain picks the hit or victim and the
// result register loads. For a flush the flush chain hands out one dirty slot
// of the file per cycle while the output register is free. Reset (synchronous,
// active low) clears all reference and dirty bits and the fill count; tag
// storage needs no clearing because only filled slots are ever compared. A
// result waiting on m_tready holds the decision stage, and s_tready stays low
// until the last result of the current request has been loaded into the output
// register.
//
module clock_writeback_block_cache (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [41:10] block_number, [9:0] file_id, upper bits zero
    input  logic [cwbc_pkg::IN_DATA_W-1:0]          s_tdata,
    // [1:0] kind
    input  logic [cwbc_pkg::KIND_W-1:0]             s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [3:0] slot, [4] writeback_needed, [14:5] old_file_id,
    // [46:15] old_block_number, upper bits zero
    output logic [cwbc_pkg::OUT_DATA_W-1:0]         m_tdata,
    // [2:0] action
    output logic [cwbc_pkg::ACTION_W-1:0]           m_tuser,
    output logic                                    m_tlast,
    input  logic                                    cfg_wr_en,
    input  logic [cwbc_pkg::CFG_W-1:0]              cfg_wr_data
);

    cwbc_pkg::cell_cmd_t                        cmd;
    cwbc_pkg::chain_t                           chain [cwbc_pkg::SLOTS+1];
    cwbc_pkg::cell_stat_t [cwbc_pkg::SLOTS-1:0] stat;
    logic [cwbc_pkg::SLOTS-1:0]                 filled;
    logic [cwbc_pkg::SLOTS-1:0]                 target;
    logic [cwbc_pkg::SLOTS-1:0]                 hit_sel;
    logic [cwbc_pkg::SLOTS-1:0]                 fl_sel;
    logic [cwbc_pkg::SLOT_W-1:0]                m_slot;
    logic                                       m_wb;
    logic [cwbc_pkg::FILE_W-1:0]                m_old_file;
    logic [cwbc_pkg::BLOCK_W-1:0]               m_old_block;

    // The chain enters slot 0 empty: nothing lower can claim priority.
    assign chain[0] = '0;

    for (genvar g = 0; g < cwbc_pkg::SLOTS; g++) begin : g_cell
        cwbc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .filled    (filled[g]),
            .target    (target[g]),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat[g])
        );
        assign hit_sel[g] = stat[g].sel_hit;
        assign fl_sel[g]  = stat[g].sel_fl;
    end

    cwbc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_kind      (s_tuser),
        .s_file      (s_tdata[cwbc_pkg::FILE_W-1:0]),
        .s_block     (s_tdata[cwbc_pkg::FILE_W+cwbc_pkg::BLOCK_W-1:cwbc_pkg::FILE_W]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_action    (m_tuser),
        .m_slot      (m_slot),
        .m_wb        (m_wb),
        .m_old_file  (m_old_file),
        .m_old_block (m_old_block),
        .m_last      (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .chain_end   (chain[cwbc_pkg::SLOTS]),
        .cmd         (cmd),
        .filled      (filled),
        .target      (target)
    );

    assign m_tdata = {{(cwbc_pkg::OUT_DATA_W - cwbc_pkg::OUT_BITS){1'b0}},
                      m_old_block, m_old_file, m_wb, m_slot};

    // At most one slot can win the hit chain or the flush chain.
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(hit_sel))
        else $error("hit chain selected more than one slot");

    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(fl_sel))
        else $error("flush chain selected more than one slot");

    // Every slot update addresses exactly one cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op != cwbc_pkg::OP_NONE |-> $onehot(target))
        else $error("slot update without a single target cell");

    // A read, write or flush keeps the input closed for the decision cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == cwbc_pkg::KIND_READ ||
         s_tuser == cwbc_pkg::KIND_WRITE || s_tuser == cwbc_pkg::KIND_FLUSH))
        |=> !s_tready)
        else $error("request accepted while the previous one was in progress");

endmodule

/* verif/clock_writeback_block_cache_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// Clock write-back block cache directory: testbench
// Drives read, write and flush requests into the request stream, keeps its
// own copy of the slot directory to predict every result, and checks each
// result transaction in order against that prediction. The page limit
// register is changed between phases, including out-of-range values and a
// limit below the number of filled slots.
// ============================================================================
module clock_writeback_block_cache_tb;

    // Timing of the run.
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    // Cycles to let pass after the last expected result, so that a request
    // that produces nothing (the unused kind) has surely left the block.
    localparam int DRAIN_CYCLES = 12;
    // Worst case is roughly 300 requests of 17 results, each result held up
    // by a long receiver stall. This limit is several times that.
    localparam int LIMIT_CYCLES = 400000;

    // Request kind 3 has no meaning; the block must ignore it.
    localparam logic [cwbc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Percentage of cycles in which each side idles outside the calm phase.
    localparam int IDLE_PERCENT = 38;

    // Number of random phases, requests per phase and the index of the calm phase.
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 25;
    localparam int CALM_PHASE       = 2;

    // One result as seen on the output stream.
    typedef struct packed {
        logic [cwbc_pkg::ACTION_W-1:0] action;
        logic [cwbc_pkg::SLOT_W-1:0]   slot;
        logic                          writeback;
        logic [cwbc_pkg::FILE_W-1:0]   old_file;
        logic [cwbc_pkg::BLOCK_W-1:0]  old_block;
        logic                          is_last;
    } cache_result_t;

    // Scoreboard: a private copy of the slot directory. Each accepted request
    // is applied to it and the results it causes are queued; each result
    // transaction from the block is checked against the oldest queued one.
    class cache_directory;
        logic [cwbc_pkg::FILE_W-1:0]  tag_file   [cwbc_pkg::SLOTS];
        logic [cwbc_pkg::BLOCK_W-1:0] tag_block  [cwbc_pkg::SLOTS];
        bit                           referenced [cwbc_pkg::SLOTS];
        bit                           dirty      [cwbc_pkg::SLOTS];
        int                           filled;
        logic [cwbc_pkg::CFG_W-1:0]   page_limit;
        cache_result_t                expected_results [$];
        int                           mismatches;

        function new();
            filled     = 0;
            page_limit = cwbc_pkg::CFG_RESET;
            mismatches = 0;
            foreach (referenced[i]) begin
                referenced[i] = 1'b0;
                dirty[i]      = 1'b0;
            end
        endfunction

        function void set_page_limit(logic [cwbc_pkg::CFG_W-1:0] value);
            page_limit = value;
        endfunction

        // The register is clamped into 1 .. SLOTS.
        function int usable_slots();
            int m;
            m = int'(page_limit);
            if (m < 1) m = 1;
            if (m > cwbc_pkg::SLOTS) m = cwbc_pkg::SLOTS;
            return m;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Appends one predicted result behind those already waiting.
        function void queue_result(cache_result_t r);
            expected_results = {expected_results, r};
        endfunction

        function void apply_request(logic [cwbc_pkg::KIND_W-1:0] kind,
                                    logic [cwbc_pkg::FILE_W-1:0] file,
                                    logic [cwbc_pkg::BLOCK_W-1:0] block);
            cache_result_t r;
            int            i;
            int            victim;
            r = '0;
            if (kind == cwbc_pkg::KIND_FLUSH) begin
                for (i = 0; i < filled; i++) begin
                    if (tag_file[i] == file && dirty[i]) begin
                        r.action    = cwbc_pkg::ACT_FLUSH_WB;
                        r.slot      = cwbc_pkg::SLOT_W'(i);
                        r.writeback = 1'b1;
                        r.old_file  = tag_file[i];
                        r.old_block = tag_block[i];
                        r.is_last   = 1'b0;
                        queue_result(r);
                        dirty[i] = 1'b0;
                    end
                end
                r         = '0;
                r.action  = cwbc_pkg::ACT_FLUSH_END;
                r.is_last = 1'b1;
                queue_result(r);
                return;
            end
            if (kind != cwbc_pkg::KIND_READ && kind != cwbc_pkg::KIND_WRITE) return;

            r.is_last = 1'b1;
            // The lowest matching filled slot wins.
            for (i = 0; i < filled; i++) begin
                if (tag_file[i] == file && tag_block[i] == block) begin
                    if (kind == cwbc_pkg::KIND_WRITE) begin
                        referenced[i] = 1'b1;
                        dirty[i]      = 1'b1;
                    end
                    r.action = (kind == cwbc_pkg::KIND_WRITE) ?
                               cwbc_pkg::ACT_WRITE_HIT : cwbc_pkg::ACT_READ_HIT;
                    r.slot   = cwbc_pkg::SLOT_W'(i);
                    queue_result(r);
                    return;
                end
            end

            if (filled < usable_slots()) begin
                victim   = filled;
                filled++;
                r.action = cwbc_pkg::ACT_FILL;
            end else begin
                // Second chance scan: clear reference bits until an
                // unreferenced slot turns up; slot 0 if none does.
                victim = 0;
                for (i = 0; i < filled; i++) begin
                    if (!referenced[i]) begin
                        victim = i;
                        break;
                    end
                    referenced[i] = 1'b0;
                end
                r.action    = cwbc_pkg::ACT_EVICT;
                r.writeback = dirty[victim];
                r.old_file  = tag_file[victim];
                r.old_block = tag_block[victim];
            end
            r.slot             = cwbc_pkg::SLOT_W'(victim);
            tag_file[victim]   = file;
            tag_block[victim]  = block;
            referenced[victim] = 1'b1;
            dirty[victim]      = (kind == cwbc_pkg::KIND_WRITE);
            queue_result(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none, actual %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("action", 32'(want.action), 32'(got.action));
            compare_field("slot", 32'(want.slot), 32'(got.slot));
            compare_field("writeback_needed", 32'(want.writeback), 32'(got.writeback));
            compare_field("old_file_id", 32'(want.old_file), 32'(got.old_file));
            compare_field("old_block_number", want.old_block, got.old_block);
            compare_field("last", 32'(want.is_last), 32'(got.is_last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [cwbc_pkg::IN_DATA_W-1:0]    s_tdata     = '0;
    logic [cwbc_pkg::KIND_W-1:0]       s_tuser     = '0;
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [cwbc_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [cwbc_pkg::ACTION_W-1:0]     m_tuser;
    logic                              m_tlast;
    logic                              cfg_wr_en   = 1'b0;
    logic [cwbc_pkg::CFG_W-1:0]        cfg_wr_data = '0;

    // During the calm phase neither side idles.
    bit                                calm_phase  = 1'b0;
    int                                cycle_count = 0;
    cache_directory                    directory   = new();

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    clock_writeback_block_cache DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic bit idle_now();
        return !calm_phase && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // The receiver decides its ready at every falling edge, once out of reset.
    always @(negedge aclk) begin
        m_tready <= aresetn && !idle_now();
    end

    // Monitor: everything is sampled at the rising edge, while the inputs,
    // which only move at the falling edge, are stable. A result is checked
    // before the request of the same edge is applied, since it always belongs
    // to an earlier request.
    always @(posedge aclk) begin
        cache_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.action    = m_tuser;
                got.slot      = m_tdata[cwbc_pkg::SLOT_W-1:0];
                got.writeback = m_tdata[cwbc_pkg::SLOT_W];
                got.old_file  = m_tdata[cwbc_pkg::SLOT_W+cwbc_pkg::FILE_W:
                                        cwbc_pkg::SLOT_W+1];
                got.old_block = m_tdata[cwbc_pkg::SLOT_W+cwbc_pkg::FILE_W+cwbc_pkg::BLOCK_W:
                                        cwbc_pkg::SLOT_W+cwbc_pkg::FILE_W+1];
                got.is_last   = m_tlast;
                directory.check_result(got);
            end
            if (s_tvalid && s_tready) begin
                directory.apply_request(s_tuser, s_tdata[cwbc_pkg::FILE_W-1:0],
                    s_tdata[cwbc_pkg::FILE_W+cwbc_pkg::BLOCK_W-1:cwbc_pkg::FILE_W]);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Presents one request, after a random number of idle cycles, and returns
    // at the rising edge where the transaction is accepted. The valid stays
    // high afterwards; the next call or drain_and_settle sets it at the next
    // falling edge, so it is assigned only once in that time step.
    task automatic send_request(logic [cwbc_pkg::KIND_W-1:0] kind,
                                logic [cwbc_pkg::FILE_W-1:0] file,
                                logic [cwbc_pkg::BLOCK_W-1:0] block);
        @(negedge aclk);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(cwbc_pkg::IN_DATA_W-cwbc_pkg::IN_BITS){1'b0}}, block, file};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Stops offering requests, waits until every expected result has come
    // back, then lets the block settle.
    task automatic drain_and_settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (directory.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the page limit register while the block is idle.
    task automatic write_page_limit(logic [cwbc_pkg::CFG_W-1:0] value);
        drain_and_settle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        directory.set_page_limit(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [cwbc_pkg::FILE_W-1:0]  file_pool   [4];
        logic [cwbc_pkg::BLOCK_W-1:0] block_pool  [6];
        logic [cwbc_pkg::CFG_W-1:0]   phase_limit [PHASES];
        logic [cwbc_pkg::KIND_W-1:0]  kind;
        logic [cwbc_pkg::FILE_W-1:0]  file;
        logic [cwbc_pkg::BLOCK_W-1:0] block;
        int                           sent;
        int                           draw;

        // A small pool of tags makes hits, refills and evictions common. The
        // pools hold the field extremes next to random values.
        file_pool[0]  = '0;
        file_pool[1]  = '1;
        file_pool[2]  = cwbc_pkg::FILE_W'($urandom);
        file_pool[3]  = cwbc_pkg::FILE_W'($urandom);
        block_pool[0] = '0;
        block_pool[1] = '1;
        for (int i = 2; i < 6; i++) block_pool[i] = $urandom;

        // The second switch drops the limit below the filled count; zero and
        // values above the slot count are clamped by the block.
        phase_limit = '{5'd31, 5'd3, 5'd16, 5'd0, 5'd8, 5'd1, 5'd12,
                        cwbc_pkg::CFG_W'($urandom_range(31))};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the reset limit of sixteen slots.
        // Fills at both tag extremes, then read and write hits.
        send_request(cwbc_pkg::KIND_READ,  10'd0,  32'd0);
        send_request(cwbc_pkg::KIND_WRITE, '1,     '1);
        send_request(cwbc_pkg::KIND_READ,  10'd0,  32'd0);
        send_request(cwbc_pkg::KIND_WRITE, 10'd0,  32'd0);
        send_request(cwbc_pkg::KIND_READ,  '1,     '1);
        // The unused kind must produce nothing and change nothing.
        send_request(KIND_UNUSED, '1,    '1);
        // A flush with one dirty slot, a repeat that finds it clean, and a
        // flush whose block number must be ignored.
        send_request(cwbc_pkg::KIND_FLUSH, 10'd0,  32'd0);
        send_request(cwbc_pkg::KIND_FLUSH, 10'd0,  32'd0);
        send_request(cwbc_pkg::KIND_FLUSH, '1,     $urandom);
        send_request(cwbc_pkg::KIND_WRITE, 10'd0,  32'd1);

        // Limit of one with three slots filled: no more fills, and the
        // second chance scan runs over all three. The fourth miss evicts
        // the dirty slot.
        write_page_limit(5'd1);
        send_request(cwbc_pkg::KIND_READ,  10'd5,  32'd5);
        send_request(cwbc_pkg::KIND_READ,  10'd6,  32'd6);
        send_request(cwbc_pkg::KIND_READ,  10'd7,  32'd7);
        send_request(cwbc_pkg::KIND_READ,  10'd8,  32'd8);

        // Zero behaves like one.
        write_page_limit(5'd0);
        send_request(cwbc_pkg::KIND_WRITE, 10'd9,  32'd9);

        // All ones behaves like the full slot count, so fills resume.
        write_page_limit('1);
        send_request(cwbc_pkg::KIND_WRITE, 10'd1,  32'd2);
        send_request(cwbc_pkg::KIND_READ,  10'd2,  32'd3);
        send_request(cwbc_pkg::KIND_FLUSH, 10'd9,  32'd0);

        // Random phases. Most requests use pooled tags, some are fully
        // random, and the unused kind shows up now and then without counting.
        for (int p = 0; p < PHASES; p++) begin
            write_page_limit(phase_limit[p]);
            calm_phase = (p == CALM_PHASE);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                draw = $urandom_range(99);
                if (draw < 40)      kind = cwbc_pkg::KIND_READ;
                else if (draw < 78) kind = cwbc_pkg::KIND_WRITE;
                else if (draw < 94) kind = cwbc_pkg::KIND_FLUSH;
                else                kind = KIND_UNUSED;
                if ($urandom_range(9) == 0) begin
                    file  = cwbc_pkg::FILE_W'($urandom);
                    block = $urandom;
                end else begin
                    file  = file_pool[$urandom_range(3)];
                    block = block_pool[$urandom_range(5)];
                end
                send_request(kind, file, block);
                if (kind != KIND_UNUSED) sent++;
            end
            calm_phase = 1'b0;
        end

        drain_and_settle();
        if (directory.mismatches == 0 && directory.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
